// File: rtl/core/tlik_pkg.sv
// Package: shared widths, CORDIC constants and cell control types for the arm IK core.
package tlik_pkg;

    localparam int CordicStagesDef = 16;
    localparam int TabLen          = 24;
    localparam int LenW            = 14;
    localparam int CoordW          = 16;
    localparam int AngW            = 16;
    localparam int VecW            = 48;   // vectoring datapath width
    localparam int RotW            = 40;   // rotation datapath width
    localparam int AccW            = 34;   // angle accumulator width
    localparam int RegIdxW         = 1;

    localparam logic [RegIdxW-1:0] RegUpperLen = 1'b0;
    localparam logic [RegIdxW-1:0] RegLowerLen = 1'b1;

    localparam logic [LenW-1:0] LenReset = 14'd5120;
    localparam logic signed [31:0] K30   = 32'sd652032875;

    // Return round(atan(2^-i) * 2^31 / pi).
    function automatic logic signed [AccW-1:0] atan_tab(input logic [4:0] i);
        logic signed [AccW-1:0] v;
        case (i)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Control pair of valid and ok flags; no cell uses it.
    typedef struct packed {
        logic vld;
        logic ok;
    } t_ctl;

endpackage

// File: rtl/core/tlik_vec_cell.sv
// One vectoring CORDIC cell: a single micro-rotation toward the x axis.
module tlik_vec_cell #(
    parameter int Idx = 0
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [tlik_pkg::VecW-1:0]    i_x,
    input  logic signed [tlik_pkg::VecW-1:0]    i_y,
    input  logic signed [tlik_pkg::AccW-1:0]    i_z,
    output logic signed [tlik_pkg::VecW-1:0]    o_x,
    output logic signed [tlik_pkg::VecW-1:0]    o_y,
    output logic signed [tlik_pkg::AccW-1:0]    o_z
);
    logic signed [tlik_pkg::VecW-1:0] dx, dy;
    logic signed [tlik_pkg::AccW-1:0] da;

    assign dx = i_y >>> Idx;
    assign dy = i_x >>> Idx;
    assign da = tlik_pkg::atan_tab(5'(Idx));

    // Rotate by the sign of y and hand to the next cell.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[tlik_pkg::VecW-1]) begin
                o_x <= i_x + dx;
                o_y <= i_y - dy;
                o_z <= i_z + da;
            end else begin
                o_x <= i_x - dx;
                o_y <= i_y + dy;
                o_z <= i_z - da;
            end
        end
    end
endmodule

// File: rtl/core/tlik_rot_cell.sv
// One rotation CORDIC cell: a single micro-rotation driving the residual angle to zero.
module tlik_rot_cell #(
    parameter int Idx = 0
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [tlik_pkg::RotW-1:0]    i_x,
    input  logic signed [tlik_pkg::RotW-1:0]    i_y,
    input  logic signed [tlik_pkg::AccW-1:0]    i_z,
    output logic signed [tlik_pkg::RotW-1:0]    o_x,
    output logic signed [tlik_pkg::RotW-1:0]    o_y,
    output logic signed [tlik_pkg::AccW-1:0]    o_z
);
    logic signed [tlik_pkg::RotW-1:0] dx, dy;
    logic signed [tlik_pkg::AccW-1:0] da;

    assign dx = i_y >>> Idx;
    assign dy = i_x >>> Idx;
    assign da = tlik_pkg::atan_tab(5'(Idx));

    // Rotate by the sign of the residual angle.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[tlik_pkg::AccW-1]) begin
                o_x <= i_x - dx;
                o_y <= i_y + dy;
                o_z <= i_z - da;
            end else begin
                o_x <= i_x + dx;
                o_y <= i_y - dy;
                o_z <= i_z + da;
            end
        end
    end
endmodule

// File: rtl/core/tlik_isqrt.sv
// Pipelined floor integer square root: one result bit per cell.
module tlik_isqrt #(
    parameter int InW = 58,
    parameter int SideW = 64
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [InW-1:0]       i_v,
    input  logic [SideW-1:0]     i_side,
    output logic [InW/2-1:0]     o_root,
    output logic [SideW-1:0]     o_side
);
    localparam int OutW = InW / 2;
    localparam int RemW = OutW + 2;

    logic [InW-1:0]   r_v   [OutW+1];
    logic [RemW-1:0]  r_rem [OutW+1];
    logic [OutW-1:0]  r_q   [OutW+1];
    logic [SideW-1:0] r_sd  [OutW+1];

    always_comb begin
        r_v[0]   = i_v;
        r_rem[0] = '0;
        r_q[0]   = '0;
        r_sd[0]  = i_side;
    end

    // Each cell brings down two bits and decides one root bit.
    for (genvar k = 0; k < OutW; k++) begin : g_cell
        logic [RemW-1:0] trial, cur;
        assign cur   = {r_rem[k][RemW-3:0], r_v[k][InW-1 -: 2]};
        assign trial = {r_q[k], 2'b01};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k+1]  <= r_v[k] << 2;
                r_sd[k+1] <= r_sd[k];
                if (cur >= trial) begin
                    r_rem[k+1] <= cur - trial;
                    r_q[k+1]   <= {r_q[k][OutW-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= cur;
                    r_q[k+1]   <= {r_q[k][OutW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_q[OutW];
    assign o_side = r_sd[OutW];
endmodule

// File: rtl/core/tlik_atan2.sv
// Vectoring CORDIC atan2: normalize, pre-rotate, then a row of cells.
module tlik_atan2 #(
    parameter int Stages = 16,
    parameter int SideW  = 8
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [63:0]                 i_y,
    input  logic signed [63:0]                 i_x,
    input  logic [SideW-1:0]                   i_side,
    output logic signed [tlik_pkg::AccW-1:0]   o_z,
    output logic [SideW-1:0]                   o_side
);
    localparam int VecW = tlik_pkg::VecW;
    localparam int AccW = tlik_pkg::AccW;
    localparam int NS   = (Stages < tlik_pkg::TabLen) ? Stages : tlik_pkg::TabLen;

    // Stage A: find leading bit of max magnitude.
    logic [63:0] mx, my, mm;
    logic [6:0]  lead;
    always_comb begin
        mx = i_x[63] ? 64'(-i_x) : 64'(i_x);
        my = i_y[63] ? 64'(-i_y) : 64'(i_y);
        mm = (mx > my) ? mx : my;
        lead = 7'd0;
        for (int b = 0; b < 64; b++) begin
            if (mm[b]) lead = 7'(b);
        end
    end

    logic signed [63:0] r_ax, r_ay;
    logic [6:0]         r_lead;
    logic               r_zero;
    logic [SideW-1:0]   r_sa;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= i_x;
            r_ay   <= i_y;
            r_lead <= lead;
            r_zero <= (mm == 64'd0);
            r_sa   <= i_side;
        end
    end

    // Stage B: scale so the lead bit sits at bit 40, then pre-rotate.
    logic signed [63:0]     sx, sy;
    logic signed [VecW-1:0] px, py;
    logic signed [AccW-1:0] pz;
    always_comb begin
        if (r_lead > 7'd40) begin
            sx = r_ax >>> (r_lead - 7'd40);
            sy = r_ay >>> (r_lead - 7'd40);
        end else begin
            sx = r_ax <<< (7'd40 - r_lead);
            sy = r_ay <<< (7'd40 - r_lead);
        end
        px = VecW'(sx);
        py = VecW'(sy);
        pz = '0;
        if (sx[63]) begin
            if (!sy[63]) begin
                px = VecW'(sy);
                py = VecW'(-sx);
                pz = AccW'(64'sd1 <<< 30);
            end else begin
                px = VecW'(-sy);
                py = VecW'(sx);
                pz = -AccW'(64'sd1 <<< 30);
            end
        end
    end

    logic signed [VecW-1:0] cx [NS+1];
    logic signed [VecW-1:0] cy [NS+1];
    logic signed [AccW-1:0] cz [NS+1];
    logic                   cn [NS+1];
    logic [SideW-1:0]       cs [NS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            cx[0] <= px;
            cy[0] <= py;
            cz[0] <= pz;
            cn[0] <= r_zero;
            cs[0] <= r_sa;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_cell
        tlik_vec_cell #(.Idx(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (cx[k]),
            .i_y   (cy[k]),
            .i_z   (cz[k]),
            .o_x   (cx[k+1]),
            .o_y   (cy[k+1]),
            .o_z   (cz[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                cn[k+1] <= cn[k];
                cs[k+1] <= cs[k];
            end
        end
    end

    assign o_z    = cn[NS] ? '0 : cz[NS];
    assign o_side = cs[NS];
endmodule

// File: rtl/core/tlik_rotate.sv
// Rotation CORDIC: L*(cos a, sin a) in Q.22 through a row of cells.
module tlik_rotate #(
    parameter int Stages = 16
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [tlik_pkg::LenW-1:0]           i_len,
    input  logic signed [tlik_pkg::AccW-1:0]    i_ang,
    output logic signed [tlik_pkg::RotW-1:0]    o_x,
    output logic signed [tlik_pkg::RotW-1:0]    o_y
);
    localparam int RotW = tlik_pkg::RotW;
    localparam int AccW = tlik_pkg::AccW;
    localparam int NS   = (Stages < tlik_pkg::TabLen) ? Stages : tlik_pkg::TabLen;

    // Scale the length by the CORDIC gain, registered.
    logic signed [63:0]     prod;
    logic signed [RotW-1:0] r_x0;
    logic signed [AccW-1:0] r_a0;
    assign prod = 64'(signed'({1'b0, i_len})) * 64'(tlik_pkg::K30);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0 <= RotW'(prod >>> 16);
            r_a0 <= i_ang;
        end
    end

    // Fold angles beyond a quarter turn.
    localparam logic signed [AccW-1:0] Quarter = AccW'(64'sd1 <<< 30);
    localparam logic signed [AccW-1:0] Half    = AccW'(64'sd1 <<< 31);

    logic signed [RotW-1:0] cx [NS+1];
    logic signed [RotW-1:0] cy [NS+1];
    logic signed [AccW-1:0] cz [NS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            cy[0] <= '0;
            if (r_a0 > Quarter) begin
                cx[0] <= -r_x0;
                cz[0] <= r_a0 - Half;
            end else if (r_a0 < -Quarter) begin
                cx[0] <= -r_x0;
                cz[0] <= r_a0 + Half;
            end else begin
                cx[0] <= r_x0;
                cz[0] <= r_a0;
            end
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_cell
        tlik_rot_cell #(.Idx(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (cx[k]),
            .i_y   (cy[k]),
            .i_z   (cz[k]),
            .o_x   (cx[k+1]),
            .o_y   (cy[k+1]),
            .o_z   (cz[k+1])
        );
    end

    assign o_x = cx[NS];
    assign o_y = cy[NS];
endmodule

// File: rtl/core/two_link_arm_inverse_kinematics_core.sv
// Top level: two-link planar arm inverse kinematics pipeline.
// Pipeline (CORDIC_STAGES capped at 24): three input stages,
// a square root row of 29 cells, one operand stage, the vectoring rows, one angle stage,
// the rotation rows and the output register.
// Throughput: one target per cycle; the whole pipe advances when the output
// register is empty or being taken, so a stalled output stalls every cell.
// Reset: synchronous active low; clears valid flags and sets both links to 20.0.
module two_link_arm_inverse_kinematics_core #(
    parameter int CORDIC_STAGES = tlik_pkg::CordicStagesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [tlik_pkg::RegIdxW-1:0] i_cfg_idx,
    input  logic [tlik_pkg::LenW-1:0]    i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] target_x, [31:16] target_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [111:0] m_axis_tdata   // [0] valid_res, [16:1] shoulder_angle,
                                        // [31:17] elbow_angle, [47:32] elbow_x,
                                        // [63:48] elbow_y, [79:64] tip_x,
                                        // [95:80] tip_y, [111:96] zero
);
    localparam int AccW = tlik_pkg::AccW;
    localparam int RotW = tlik_pkg::RotW;
    localparam int LenW = tlik_pkg::LenW;
    localparam int NS   = (CORDIC_STAGES < tlik_pkg::TabLen) ? CORDIC_STAGES
                                                             : tlik_pkg::TabLen;
    localparam int SqW  = 58;
    localparam int SqD  = SqW / 2;

    logic [LenW-1:0] r_l1, r_l2;
    logic en;

    // Write link length registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= tlik_pkg::LenReset;
            r_l2 <= tlik_pkg::LenReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlik_pkg::RegUpperLen: r_l1 <= i_cfg_data;
                tlik_pkg::RegLowerLen: r_l2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid shift line: one bit per pipeline cell.
    localparam int Lat = 3 + SqD + 1 + (2 + NS) + 1 + (2 + NS);
    logic [Lat-1:0] r_vld;
    logic           r_ov;
    assign en            = !r_ov || m_axis_tready;
    assign s_axis_tready = en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Lat-2:0], s_axis_tvalid};
        end
    end

    // Stage 1: squares.
    logic signed [15:0] in_x, in_y;
    assign in_x = s_axis_tdata[15:0];
    assign in_y = s_axis_tdata[31:16];
    logic signed [31:0] r_xx, r_yy;
    logic [27:0]        r_l11, r_l22, r_l12;
    logic signed [15:0] r1_x, r1_y;
    logic [LenW-1:0]    r1_l1, r1_l2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xx  <= in_x * in_x;
            r_yy  <= in_y * in_y;
            r_l11 <= r_l1 * r_l1;
            r_l22 <= r_l2 * r_l2;
            r_l12 <= r_l1 * r_l2;
            r1_x  <= in_x;
            r1_y  <= in_y;
            r1_l1 <= r_l1;
            r1_l2 <= r_l2;
        end
    end

    // Stage 2: num, den, reach check.
    logic signed [34:0] num2;
    logic signed [34:0] den2;
    assign num2 = 35'(r_xx) + 35'(r_yy) - 35'(signed'({1'b0, r_l11}))
                  - 35'(signed'({1'b0, r_l22}));
    assign den2 = 35'(signed'({1'b0, r_l12, 1'b0}));
    logic signed [34:0] r2_num, r2_den, r2_ap;
    logic               r2_ok;
    logic signed [15:0] r2_x, r2_y;
    logic [LenW-1:0]    r2_l1, r2_l2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_num <= num2;
            r2_den <= den2;
            r2_ap  <= num2 + 35'(signed'({1'b0, r_l11, 1'b0}));
            r2_ok  <= (den2 != 0) && (num2 <= den2) && (num2 >= -den2);
            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_l1  <= r1_l1;
            r2_l2  <= r1_l2;
        end
    end

    // Stage 3: radicand den^2 - num^2.
    logic [SqW-1:0] r3_rad;
    logic signed [34:0] r3_num, r3_ap;
    logic               r3_ok;
    logic signed [15:0] r3_x, r3_y;
    logic [LenW-1:0]    r3_l1, r3_l2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_rad <= r2_ok ? SqW'(70'(r2_den) * 70'(r2_den) - 70'(r2_num) * 70'(r2_num))
                            : '0;
            r3_num <= r2_num;
            r3_ap  <= r2_ap;
            r3_ok  <= r2_ok;
            r3_x   <= r2_x;
            r3_y   <= r2_y;
            r3_l1  <= r2_l1;
            r3_l2  <= r2_l2;
        end
    end

    // Square root row; side data rides along.
    localparam int SdW = 35 + 35 + 1 + 16 + 16 + LenW + LenW;
    logic [SqD-1:0] s_root;
    logic [SdW-1:0] sq_side;
    tlik_isqrt #(.InW(SqW), .SideW(SdW)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    (r3_rad),
        .i_side ({r3_num, r3_ap, r3_ok, r3_x, r3_y, r3_l1, r3_l2}),
        .o_root (s_root),
        .o_side (sq_side)
    );
    logic signed [34:0] s_num, s_ap;
    logic               s_ok;
    logic signed [15:0] s_x, s_y;
    logic [LenW-1:0]    s_l1, s_l2;
    assign {s_num, s_ap, s_ok, s_x, s_y, s_l1, s_l2} = sq_side;

    // Stage 4: shoulder operands.
    logic signed [63:0] r4_sy, r4_sx, r4_s, r4_num;
    logic               r4_ok;
    logic [LenW-1:0]    r4_l1, r4_l2;
    logic signed [63:0] sp;
    assign sp = 64'(signed'({1'b0, s_root}));
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sy  <= 64'(s_y) * 64'(s_ap) - 64'(s_x) * sp;
            r4_sx  <= 64'(s_x) * 64'(s_ap) + 64'(s_y) * sp;
            r4_s   <= sp;
            r4_num <= 64'(s_num);
            r4_ok  <= s_ok;
            r4_l1  <= s_l1;
            r4_l2  <= s_l2;
        end
    end

    // Elbow and shoulder atan2 rows, run side by side.
    localparam int ESdW = 1 + LenW + LenW;
    logic signed [AccW-1:0] ez, shz;
    logic [ESdW-1:0]        e_side;
    logic [0:0]             sh_side;
    tlik_atan2 #(.Stages(CORDIC_STAGES), .SideW(ESdW)) u_elb (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_y    (r4_s),
        .i_x    (r4_num),
        .i_side ({r4_ok, r4_l1, r4_l2}),
        .o_z    (ez),
        .o_side (e_side)
    );
    tlik_atan2 #(.Stages(CORDIC_STAGES), .SideW(1)) u_sho (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_y    (r4_sy),
        .i_x    (r4_sx),
        .i_side (r4_ok),
        .o_z    (shz),
        .o_side (sh_side)
    );
    logic            a_ok;
    logic [LenW-1:0] a_l1, a_l2;
    assign {a_ok, a_l1, a_l2} = e_side;

    // Stage 5: round angles, clamp elbow, form joint angle sum.
    logic signed [AccW-1:0] er, shr;
    logic [15:0]            e16;
    logic [15:0]            sh16;
    always_comb begin
        er  = (ez + AccW'(32768)) >>> 16;
        shr = (shz + AccW'(32768)) >>> 16;
        sh16 = shr[15:0];
        if (er < 0) e16 = 16'd0;
        else if (er > AccW'(32768)) e16 = 16'd32768;
        else e16 = er[15:0];
    end
    logic [15:0]            r5_sh, r5_e;
    logic                   r5_ok;
    logic [LenW-1:0]        r5_l1, r5_l2;
    logic signed [AccW-1:0] r5_a1, r5_a2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_sh <= sh16;
            r5_e  <= e16;
            r5_ok <= a_ok;
            r5_l1 <= a_l1;
            r5_l2 <= a_l2;
            r5_a1 <= AccW'(signed'({sh16, 16'd0}));
            r5_a2 <= AccW'(signed'({16'(sh16 + e16), 16'd0}));
        end
    end

    // Forward kinematics rows for both links.
    logic signed [RotW-1:0] ex, ey, lx, ly;
    tlik_rotate #(.Stages(CORDIC_STAGES)) u_rot1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_len (r5_l1),
        .i_ang (r5_a1),
        .o_x   (ex),
        .o_y   (ey)
    );
    tlik_rotate #(.Stages(CORDIC_STAGES)) u_rot2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_len (r5_l2),
        .i_ang (r5_a2),
        .o_x   (lx),
        .o_y   (ly)
    );

    // Delay angle results alongside the rotation rows.
    localparam int RD = 2 + NS;
    logic [32:0] r_dl [RD];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl[0] <= {r5_ok, r5_sh, r5_e};
            for (int k = 1; k < RD; k++) r_dl[k] <= r_dl[k-1];
        end
    end
    logic        f_ok;
    logic [15:0] f_sh, f_e;
    assign {f_ok, f_sh, f_e} = r_dl[RD-1];

    // Round Q.22 to Q.8 and saturate.
    function automatic logic [15:0] q8sat(input logic signed [RotW:0] v);
        logic signed [RotW:0] t;
        t = (v + (RotW+1)'(8192)) >>> 14;
        if (t > (RotW+1)'(32767)) return 16'h7FFF;
        if (t < -(RotW+1)'(32768)) return 16'h8000;
        return t[15:0];
    endfunction

    // Output register.
    logic [111:0] r_od;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_vld[Lat-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (f_ok) begin
                r_od <= {16'd0,
                         q8sat((RotW+1)'(ey) + (RotW+1)'(ly)),
                         q8sat((RotW+1)'(ex) + (RotW+1)'(lx)),
                         q8sat((RotW+1)'(ey)),
                         q8sat((RotW+1)'(ex)),
                         f_e[15] ? 15'h7FFF : f_e[14:0],
                         f_sh, 1'b1};
            end else begin
                r_od <= '0;
            end
        end
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
endmodule

// File: rtl/core/tlik_checker.sv
// Port checker for the arm IK core, bound to the top level.
module tlik_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata
);
    // Hold a stalled output beat.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped under stall");

    // Unreachable beats carry all zeros.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata == '0)
        else $error("unreachable beat not zero");

    // Input is open whenever output is free.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Pad bits stay zero.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[111:96] == 16'd0)
        else $error("pad bits set");
endmodule

bind two_link_arm_inverse_kinematics_core tlik_checker u_tlik_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: sim/two_link_arm_inverse_kinematics_core_tb.sv
// Testbench: self-checking stream test of the two-link arm inverse kinematics core.
module two_link_arm_inverse_kinematics_core_tb;

    localparam int       Stages = tlik_pkg::CordicStagesDef;
    localparam int       TabLen = tlik_pkg::TabLen;
    localparam int       LenW   = tlik_pkg::LenW;
    localparam int       Settle = 200;
    localparam longint   K30L   = 64'sd652032875;

    typedef struct packed {
        logic        reach;
        logic [15:0] shoulder;
        logic [14:0] elbow;
        logic [15:0] elbow_x;
        logic [15:0] elbow_y;
        logic [15:0] tip_x;
        logic [15:0] tip_y;
    } t_ik_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [tlik_pkg::RegIdxW-1:0] i_cfg_idx = tlik_pkg::RegUpperLen;
    logic [LenW-1:0]              i_cfg_data = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [31:0]                  s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [111:0]                 m_axis_tdata;

    logic [31:0] target_q[$];
    t_ik_result  pose_q[$];
    longint      upper_len = 5120;
    longint      lower_len = 5120;
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_reach = 0;
    int          cyc = 0;
    int          hold_cnt = 0;
    bit          hold_done = 1'b0;

    two_link_arm_inverse_kinematics_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) cyc <= cyc + 1;

    // Return floor square root.
    function automatic longint isqrt(input longint v);
        logic [63:0] r, b, w;
        w = v;
        r = 0;
        b = 64'd1 << 62;
        while (b > w) b = b >> 2;
        while (b != 0) begin
            if (w >= r + b) begin
                w = w - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Return atan2(y, x) with 2^32 per turn, by normalized vectoring CORDIC.
    function automatic longint vector_angle(input longint y, input longint x);
        longint m, z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        m = (x < 0 ? -x : x);
        if ((y < 0 ? -y : y) > m) m = (y < 0 ? -y : y);
        while (m >= (64'sd1 <<< 41)) begin
            x = x >>> 1;
            y = y >>> 1;
            m = m >>> 1;
        end
        while (m < (64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = 64'sd1 <<< 30;
            end else begin
                x = -y;
                y = t;
                z = -(64'sd1 <<< 30);
            end
        end
        for (int i = 0; i < Stages && i < TabLen; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(tlik_pkg::atan_tab(5'(i)));
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(tlik_pkg::atan_tab(5'(i)));
            end
        end
        return z;
    endfunction

    // Compute len*(cos a, sin a) in Q.22 by rotation CORDIC.
    function automatic void link_vector(input longint len, input logic [31:0] ang,
                                        output longint ox, output longint oy);
        longint x, y, a, dx, dy;
        a = longint'($signed(ang));
        x = ((len <<< 14) * K30L) >>> 30;
        y = 0;
        if (a > (64'sd1 <<< 30)) begin
            a = a - (64'sd1 <<< 31);
            x = -x;
        end else if (a < -(64'sd1 <<< 30)) begin
            a = a + (64'sd1 <<< 31);
            x = -x;
        end
        for (int i = 0; i < Stages && i < TabLen; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0) begin
                x = x - dx;
                y = y + dy;
                a = a - longint'(tlik_pkg::atan_tab(5'(i)));
            end else begin
                x = x + dx;
                y = y - dy;
                a = a + longint'(tlik_pkg::atan_tab(5'(i)));
            end
        end
        ox = x;
        oy = y;
    endfunction

    function automatic logic [15:0] to_coord(input longint v);
        longint r;
        r = (v + 8192) >>> 14;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // Solve the arm pose for one target under the current link lengths.
    function automatic t_ik_result solve_pose(input logic [31:0] t);
        t_ik_result  p;
        longint      x, y, num, den, s, e, sh, ap, ex, ey, lx, ly;
        logic [31:0] a1, a2;
        p = '0;
        x = longint'($signed(t[15:0]));
        y = longint'($signed(t[31:16]));
        num = x * x + y * y - upper_len * upper_len - lower_len * lower_len;
        den = 2 * upper_len * lower_len;
        if (den == 0 || num > den || num < -den) return p;
        s = isqrt(den * den - num * num);
        e = (vector_angle(s, num) + 32768) >>> 16;
        if (e < 0) e = 0;
        if (e > 32768) e = 32768;
        ap = 2 * upper_len * upper_len + num;
        sh = (vector_angle(y * ap - x * s, x * ap + y * s) + 32768) >>> 16;
        a1 = {sh[15:0], 16'h0};
        a2 = a1 + {e[15:0], 16'h0};
        link_vector(upper_len, a1, ex, ey);
        link_vector(lower_len, a2, lx, ly);
        p.reach    = 1'b1;
        p.shoulder = sh[15:0];
        p.elbow    = (e > 32767) ? 15'h7FFF : e[14:0];
        p.elbow_x  = to_coord(ex);
        p.elbow_y  = to_coord(ey);
        p.tip_x    = to_coord(ex + lx);
        p.tip_y    = to_coord(ey + ly);
        return p;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name, want, got);
            errors++;
        end
    endfunction

    function automatic bit calm();
        return (cyc % 5000) < 700;
    endfunction

    // Driver: predict on every accepted beat, then offer the next pending target.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                pose_q.push_back(solve_pose(s_axis_tdata));
                n_sent++;
            end
            if (target_q.size() > 0 && (calm() || $urandom_range(99) >= 38)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= target_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_ik_result want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[31:17],
                   m_axis_tdata[47:32], m_axis_tdata[63:48], m_axis_tdata[79:64],
                   m_axis_tdata[95:80]};
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual %h",
                         $realtime, m_axis_tdata);
                errors++;
            end else begin
                want = pose_q.pop_front();
                n_checked++;
                if (want.reach) n_reach++;
                check_field("valid_res", want.reach, got.reach);
                check_field("shoulder_angle", want.shoulder, got.shoulder);
                check_field("elbow_angle", want.elbow, got.elbow);
                check_field("elbow_x", want.elbow_x, got.elbow_x);
                check_field("elbow_y", want.elbow_y, got.elbow_y);
                check_field("tip_x", want.tip_x, got.tip_x);
                check_field("tip_y", want.tip_y, got.tip_y);
            end
        end
    end

    // Receiver: hold off once for a long stretch so the pipe fills and backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (!hold_done && n_sent >= 400) begin
            hold_done     <= 1'b1;
            hold_cnt      <= 300;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt      <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm() || $urandom_range(99) >= 38;
        end
    end

    task automatic drain();
        while (target_q.size() > 0 || s_axis_tvalid || pose_q.size() > 0) @(posedge i_clk);
        repeat (Settle) @(posedge i_clk);
    endtask

    task automatic set_links(input longint l1, input longint l2);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= tlik_pkg::RegUpperLen;
        i_cfg_data <= l1[LenW-1:0];
        @(posedge i_clk);
        i_cfg_idx  <= tlik_pkg::RegLowerLen;
        i_cfg_data <= l2[LenW-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        upper_len = l1;
        lower_len = l2;
    endtask

    function automatic void add_target(input int x, input int y);
        target_q.push_back({y[15:0], x[15:0]});
    endfunction

    // Mostly targets near the workspace, some across the full field range.
    task automatic add_random(input int n);
        int  span, x, y;
        span = int'(upper_len + lower_len) + 2;
        if (span > 32767) span = 32767;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 80) begin
                x = $urandom_range(2 * span) - span;
                y = $urandom_range(2 * span) - span;
            end else begin
                x = $signed(16'($urandom));
                y = $signed(16'($urandom));
            end
            add_target(x, y);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: origin, full reach, axes, field extremes, near origin.
        add_target(0, 0);
        add_target(10240, 0);
        add_target(-10240, 0);
        add_target(0, 10240);
        add_target(0, -10240);
        add_target(10241, 0);
        add_target(7240, 7240);
        add_target(-5120, 5120);
        add_target(1, 0);
        add_target(-1, -1);
        add_target(32767, 32767);
        add_target(-32768, -32768);
        add_target(-32768, 32767);
        add_target(32767, -32768);
        add_target(-10240, -1);
        add_target(-10240, 1);
        drain();

        set_links(16383, 16383);
        add_target(32767, 0);
        add_target(-32768, 0);
        add_target(0, 32767);
        add_target(23000, 23000);
        add_random(150);
        drain();

        set_links(1, 1);
        add_target(2, 0);
        add_target(0, 0);
        add_target(-1, 1);
        add_random(80);
        drain();

        set_links(16383, 1);
        add_target(16383, 0);
        add_target(-16384, 0);
        add_random(100);
        drain();

        set_links(0, 5120);
        add_target(5120, 0);
        add_target(0, 0);
        drain();

        set_links(1200, 3700);
        add_random(250);
        drain();

        set_links(5120, 5120);
        add_random(500);
        drain();

        set_links($urandom_range(16383, 1), $urandom_range(16383, 1));
        add_random(200);
        drain();

        $display("Checked %0d result beats of %0d targets, %0d reachable,", n_checked,
                 n_sent, n_reach);
        $display("over eight link-length settings including extremes and back-pressure.");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(12 * 2000000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
rtl/core/tlik_pkg.sv
rtl/core/tlik_vec_cell.sv
rtl/core/tlik_rot_cell.sv
rtl/core/tlik_isqrt.sv
rtl/core/tlik_atan2.sv
rtl/core/tlik_rotate.sv
rtl/core/two_link_arm_inverse_kinematics_core.sv
rtl/core/tlik_checker.sv
sim/two_link_arm_inverse_kinematics_core_tb.sv
